// ----- hdl/wall_and_image_point_unit_macros.svh -----
// Assertion macros for the wall and image point unit.
// Used by the port checker; no other dependencies.
`ifndef WALL_AND_IMAGE_POINT_UNIT_MACROS_SVH
`define WALL_AND_IMAGE_POINT_UNIT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define WIP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wip assertion failed");

// Clocked check that also runs across reset
`define WIP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("wip assertion failed");

`endif

// ----- hdl/wip_pkg.sv -----
// Shared types, constants and helpers of the wall and image point unit.
// No dependencies.
package wip_pkg;

  localparam int FifoDepth = 4;
  localparam logic [30:0] CutoffReset = 31'd1;

  // word passed from front to back through the queue
  typedef struct packed {
    logic [2:0][31:0] c;
    logic [2:0][31:0] n;
    logic [31:0]      wdist;
    logic [32:0]      delta;
  } item_t;

  // payload carried alongside the arithmetic pipeline
  typedef struct packed {
    logic [2:0][31:0] c;
    logic [2:0][31:0] nmag;
    logic [2:0]       nneg;
    logic [31:0]      dmag;
    logic             dneg;
    logic [31:0]      emag;
    logic             eneg;
  } pl_t;

  // clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -37'sh0_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- hdl/wip_front.sv -----
// Front end: input register, cutoff register and offset selection.
// Depends on wip_pkg.
module wip_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [30:0]    geom_cutoff_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [31:0]    corr_x_i,
  input  logic [31:0]    corr_y_i,
  input  logic [31:0]    corr_z_i,
  input  logic [31:0]    norm_x_i,
  input  logic [31:0]    norm_y_i,
  input  logic [31:0]    norm_z_i,
  input  logic [31:0]    wall_dist_i,
  input  logic [31:0]    inner_offset_i,
  input  logic [31:0]    outer_offset_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output wip_pkg::item_t q_item_o
);
  import wip_pkg::*;

  logic [30:0] cutoff_q;
  logic        f_valid_q;
  item_t       f_item_q, f_item_d;
  logic signed [32:0] cut33, d33, hi33, he33;

  // cutoff register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cutoff_q <= CutoffReset;
    else if (cfg_we_i) cutoff_q <= geom_cutoff_i;
  end

  // pick the image offset
  always_comb begin
    cut33 = $signed({2'b00, cutoff_q});
    d33   = $signed({wall_dist_i[31], wall_dist_i});
    hi33  = $signed({inner_offset_i[31], inner_offset_i});
    he33  = $signed({outer_offset_i[31], outer_offset_i});
    f_item_d.c     = {corr_z_i, corr_y_i, corr_x_i};
    f_item_d.n     = {norm_z_i, norm_y_i, norm_x_i};
    f_item_d.wdist = wall_dist_i;
    priority if (d33 > cut33) f_item_d.delta = he33;
    else if (hi33 <= cut33) f_item_d.delta = -d33;
    else f_item_d.delta = hi33;
  end

  assign in_ready_o = !f_valid_q || q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_valid_q <= 1'b0;
    else if (in_ready_o) f_valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) f_item_q <= f_item_d;
  end

  assign q_valid_o = f_valid_q;
  assign q_item_o  = f_item_q;
endmodule

// ----- hdl/wip_fifo.sv -----
// Short queue between front and back end.
// Depends on wip_pkg.
module wip_fifo #(
  parameter int DEPTH = wip_pkg::FifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  wip_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output wip_pkg::item_t pop_item_o
);
  import wip_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_item_o = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end
endmodule

// ----- hdl/wip_back.sv -----
// Back end: squares, pipelined square root, three pipelined dividers,
// direction products, sums and saturating output register. Depends on wip_pkg.
module wip_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  wip_pkg::item_t q_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    wall_x_o,
  output logic [31:0]    wall_y_o,
  output logic [31:0]    wall_z_o,
  output logic [31:0]    image_x_o,
  output logic [31:0]    image_y_o,
  output logic [31:0]    image_z_o,
  output logic           zero_normal_o
);
  import wip_pkg::*;

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign q_ready_o = en;

  // stage A: magnitudes and signs
  logic va_q;
  pl_t  pa_q, pa_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_d.c[i]    = q_item_i.c[i];
      pa_d.nneg[i] = q_item_i.n[i][31];
      pa_d.nmag[i] = q_item_i.n[i][31] ? 32'(-q_item_i.n[i]) : q_item_i.n[i];
    end
    pa_d.dneg = q_item_i.wdist[31];
    pa_d.dmag = q_item_i.wdist[31] ? 32'(-q_item_i.wdist) : q_item_i.wdist;
    pa_d.eneg = q_item_i.delta[32];
    pa_d.emag = q_item_i.delta[32] ? 32'(-q_item_i.delta) : q_item_i.delta[31:0];
  end

  // stage B: squares
  logic             vb_q;
  pl_t              pb_q;
  logic [2:0][63:0] sq_q;

  // stage C: sum of squares
  logic        vc_q;
  pl_t         pc_q;
  logic [63:0] ss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= q_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= pa_d;
      pb_q <= pa_q;
      for (int i = 0; i < 3; i++) sq_q[i] <= pa_q.nmag[i] * pa_q.nmag[i];
      pc_q <= pb_q;
      ss_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // square root, one result bit per stage
  logic [63:0] sr_rem  [33];
  logic [31:0] sr_root [33];
  pl_t         sr_pl   [33];
  logic        sr_v    [33];
  logic        sr_z    [33];

  assign sr_rem[0]  = ss_q;
  assign sr_root[0] = '0;
  assign sr_pl[0]   = pc_q;
  assign sr_v[0]    = vc_q;
  assign sr_z[0]    = ss_q == '0;

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam int K = 31 - j;
    logic [65:0] trial;
    logic        take;
    assign trial = ({34'd0, sr_root[j]} << (K + 1)) + (66'd1 << (2 * K));
    assign take  = {2'b00, sr_rem[j]} >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sr_v[j+1] <= 1'b0;
      else if (en) sr_v[j+1] <= sr_v[j];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_rem[j+1]  <= take ? sr_rem[j] - trial[63:0] : sr_rem[j];
        sr_root[j+1] <= take ? (sr_root[j] | (32'd1 << K)) : sr_root[j];
        sr_pl[j+1]   <= sr_pl[j];
        sr_z[j+1]    <= sr_z[j];
      end
    end
  end

  // three restoring dividers, one quotient bit per stage
  logic [2:0][63:0] dv_rem [32];
  logic [2:0][30:0] dv_q   [32];
  logic [31:0]      dv_len [32];
  pl_t              dv_pl  [32];
  logic             dv_v   [32];
  logic             dv_z   [32];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = ({32'd0, sr_pl[32].nmag[i]} << 30) + {33'd0, sr_root[32][31:1]};
      dv_q[0][i]   = '0;
    end
  end
  assign dv_len[0] = sr_root[32];
  assign dv_pl[0]  = sr_pl[32];
  assign dv_v[0]   = sr_v[32];
  assign dv_z[0]   = sr_z[32];

  for (genvar j = 0; j < 31; j++) begin : g_div
    localparam int I = 30 - j;
    logic [63:0] dsh;
    assign dsh = {32'd0, dv_len[j]} << I;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v[j+1] <= 1'b0;
      else if (en) dv_v[j+1] <= dv_v[j];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[j][i] >= dsh) begin
            dv_rem[j+1][i] <= dv_rem[j][i] - dsh;
            dv_q[j+1][i]   <= dv_q[j][i] | (31'd1 << I);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
        dv_len[j+1] <= dv_len[j];
        dv_pl[j+1]  <= dv_pl[j];
        dv_z[j+1]   <= dv_z[j];
      end
    end
  end

  // products with the unit direction
  logic             vm_q, vr_q;
  logic [2:0][62:0] pd_q, pe_q;
  logic [2:0]       sd_q, se_q, sdr_q, ser_q;
  logic [2:0][31:0] cm_q, cr_q;
  logic             zm_q, zr_q;
  logic [2:0][33:0] rd_q, re_q;
  logic [30:0]      u [3];

  always_comb begin
    for (int i = 0; i < 3; i++) u[i] = dv_z[31] ? '0 : dv_q[31][i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vr_q <= 1'b0;
    end else if (en) begin
      vm_q <= dv_v[31];
      vr_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd_q[i] <= dv_pl[31].dmag * u[i];
        pe_q[i] <= dv_pl[31].emag * u[i];
        sd_q[i] <= dv_pl[31].dneg ^ dv_pl[31].nneg[i];
        se_q[i] <= dv_pl[31].eneg ^ dv_pl[31].nneg[i];
        // round half away from zero on magnitudes, drop 30 fraction bits
        rd_q[i] <= 34'(({1'b0, pd_q[i]} + 64'(1 << 29)) >> 30);
        re_q[i] <= 34'(({1'b0, pe_q[i]} + 64'(1 << 29)) >> 30);
      end
      cm_q  <= dv_pl[31].c;
      zm_q  <= dv_z[31];
      cr_q  <= cm_q;
      zr_q  <= zm_q;
      sdr_q <= sd_q;
      ser_q <= se_q;
    end
  end

  // sums at full width, saturated into the output register
  logic              out_valid_q, zero_q;
  logic [2:0][31:0]  wall_q, image_q;
  logic signed [36:0] tw [3];
  logic signed [36:0] ti [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tw[i] = 37'($signed(cr_q[i]))
            - (sdr_q[i] ? -$signed({3'b000, rd_q[i]}) : $signed({3'b000, rd_q[i]}));
      ti[i] = tw[i]
            + (ser_q[i] ? -$signed({3'b000, re_q[i]}) : $signed({3'b000, re_q[i]}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vr_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        wall_q[i]  <= sat32(tw[i]);
        image_q[i] <= sat32(ti[i]);
      end
      zero_q <= zr_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wall_x_o      = wall_q[0];
  assign wall_y_o      = wall_q[1];
  assign wall_z_o      = wall_q[2];
  assign image_x_o     = image_q[0];
  assign image_y_o     = image_q[1];
  assign image_z_o     = image_q[2];
  assign zero_normal_o = zero_q;
endmodule

// ----- hdl/wall_and_image_point_unit.sv -----
// Top level of the wall and image point unit: front end, queue, back end.
// Depends on wip_pkg, wip_front, wip_fifo, wip_back.
//
// Takes one point word per clock and returns one result word per clock when
// the output side keeps up. The path is 71 registers deep: front register,
// the queue's storage, the magnitude, square and sum registers, 32 square-root
// stages, 31 stages for each of the three unit-normal dividers, one product
// stage, one rounding stage and the saturating output register. The whole
// back end advances only while its output register can move; the queue and
// front register keep taking words during a short output stall.
module wall_and_image_point_unit #(
  parameter int FIFO_DEPTH = wip_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] geom_cutoff_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] corr_x_i,
  input  logic [31:0] corr_y_i,
  input  logic [31:0] corr_z_i,
  input  logic [31:0] norm_x_i,
  input  logic [31:0] norm_y_i,
  input  logic [31:0] norm_z_i,
  input  logic [31:0] wall_dist_i,
  input  logic [31:0] inner_offset_i,
  input  logic [31:0] outer_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] wall_x_o,
  output logic [31:0] wall_y_o,
  output logic [31:0] wall_z_o,
  output logic [31:0] image_x_o,
  output logic [31:0] image_y_o,
  output logic [31:0] image_z_o,
  output logic        zero_normal_o
);
  import wip_pkg::*;

  logic  f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  wip_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .geom_cutoff_i,
    .in_valid_i, .in_ready_o,
    .corr_x_i, .corr_y_i, .corr_z_i,
    .norm_x_i, .norm_y_i, .norm_z_i,
    .wall_dist_i, .inner_offset_i, .outer_offset_i,
    .q_valid_o (f_valid),
    .q_ready_i (f_ready),
    .q_item_o  (f_item)
  );

  wip_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  wip_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (b_valid),
    .q_ready_o (b_ready),
    .q_item_i  (b_item),
    .out_valid_o, .out_ready_i,
    .wall_x_o, .wall_y_o, .wall_z_o,
    .image_x_o, .image_y_o, .image_z_o,
    .zero_normal_o
  );
endmodule

// ----- hdl/wip_checker.sv -----
// Port-level checker for the wall and image point unit, bound to the top.
// Depends on wall_and_image_point_unit_macros.svh.
`include "wall_and_image_point_unit_macros.svh"
module wip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] wall_x_o,
  input logic [31:0] wall_y_o,
  input logic [31:0] wall_z_o,
  input logic [31:0] image_x_o,
  input logic [31:0] image_y_o,
  input logic [31:0] image_z_o,
  input logic        zero_normal_o
);
  logic [192:0] res_word;
  logic         same_pt;

  assign res_word = {wall_x_o, wall_y_o, wall_z_o, image_x_o, image_y_o, image_z_o,
                     zero_normal_o};
  assign same_pt  = wall_x_o == image_x_o && wall_y_o == image_y_o &&
                    wall_z_o == image_z_o;

  // a stalled word stays put
  `WIP_ASSERT(a_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_word))
  // zero normal: no displacement, wall and image coincide
  `WIP_ASSERT(a_zero, out_valid_o && zero_normal_o |-> same_pt)
  // nothing comes out right after reset
  `WIP_ASSERT_ALWAYS(a_rst, !rst_ni |=> !out_valid_o)
endmodule

bind wall_and_image_point_unit wip_checker u_wip_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i,
  .wall_x_o, .wall_y_o, .wall_z_o,
  .image_x_o, .image_y_o, .image_z_o, .zero_normal_o
);
